/* hdl/longest_majority_above_window_defines.svh */
// Assertion macros shared by the RTL. Each use sits on a line of its own.
`ifndef LONGEST_MAJORITY_ABOVE_WINDOW_DEFINES_SVH
`define LONGEST_MAJORITY_ABOVE_WINDOW_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LMAW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define LMAW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/lmaw_pkg.sv */
`default_nettype none

package lmaw_pkg;

    localparam int MAX_LEN_DEFAULT = 1024;

    localparam int SAMPLE_W    = 8;
    localparam int THRESHOLD_W = 8;
    localparam int BEST_W      = 11;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(8);

endpackage

`default_nettype wire

/* hdl/longest_majority_above_window.sv */
// Longest run, within the current sequence, in which samples above a
// threshold outnumber samples at or below it.
//
// Channels: an input channel (sample, first_of_sequence) and a result
// channel (best_length, overflow), both with valid and stall; a
// transaction completes when valid is high and stall is low. One result
// per input transaction, in order. A write channel (cfg_valid, cfg_ready,
// cfg_data) loads the threshold; cfg_ready is always high. Write it only
// while no transaction is in flight.
//
// After the edge that accepts the input, the result passes the memory read
// stage, then the output register, where out_valid rises. Throughput:
// 1 transaction per cycle while the receiver does not stall, set by the
// single read and single write of the first-position memory per sample.
// first_of_sequence restarts the sequence with this sample as its first.
// Past MAX_LEN samples, results carry overflow and the sample is dropped.
// Reset: threshold returns to 8 and the sequence is empty; the memory is
// not cleared (a high-water mark of the balance tracks which entries hold
// data). When the receiver stalls with a result waiting, the whole
// pipeline holds and in_stall rises in the same cycle.

`default_nettype none

`include "longest_majority_above_window_defines.svh"

module longest_majority_above_window
    import lmaw_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [THRESHOLD_W-1:0] cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_W-1:0]    sample,
    input  wire logic                   first_of_sequence,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BEST_W-1:0]           best_length,
    output logic                        overflow
);

    // Count/position width, signed balance width, memory geometry.
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int BW    = CW + 1;
    localparam int DEPTH = MAX_LEN + 2;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_LEN);

    // Configuration
    logic [THRESHOLD_W-1:0] threshold_reg;

    // Sequence state
    logic signed [BW-1:0]   balance_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          top_reg;       // highest balance recorded so far
    logic                   zero_seen_reg; // balance zero recorded

    // First-position memory: entry s holds the first position where the
    // balance was s. Entry s >= 1 holds data iff s <= top_reg, entry zero
    // iff zero_seen_reg.
    logic [CW-1:0]          pos_mem [DEPTH];
    logic [CW-1:0]          rd_data_reg;

    // Lookup stage
    logic                   s1_valid_reg;
    logic                   s1_restart_reg;
    logic                   s1_full_reg;
    logic                   s1_neg_reg;
    logic                   s1_hit_reg;
    logic [CW-1:0]          s1_pos_reg;
    logic [CW-1:0]          best_reg;
    logic [CW-1:0]          best_next;
    logic                   drop_done;

    // Output register
    logic                   out_valid_reg;
    logic [BEST_W-1:0]      best_length_reg;
    logic                   overflow_reg;

    // Intake stage signals
    logic                   advance;
    logic                   accept;
    logic [CW-1:0]          eff_count;
    logic signed [BW-1:0]   eff_balance;
    logic [CW-1:0]          eff_top;
    logic                   eff_zero;
    logic                   full;
    logic                   good;
    logic [CW-1:0]          pos;
    logic signed [BW-1:0]   balance_next;
    logic                   nonneg;
    logic [CW-1:0]          bal_idx;
    logic                   hit;
    logic                   new_top;
    logic                   new_zero;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [CW-1:0]          best_cur;
    logic [CW-1:0]          run_len;

    // Handshakes: the pipeline moves whenever the output slot frees up.
    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign accept    = in_valid && advance;

    assign out_valid   = out_valid_reg;
    assign best_length = best_length_reg;
    assign overflow    = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    // Intake: apply restart, step the balance, and form the memory accesses.
    // The write goes to the new balance entry and the read to the entry one
    // above it, so the two never collide and no forwarding is needed; any
    // entry written by an earlier sample is already in the memory.
    always_comb
    begin
        eff_count   = first_of_sequence ? '0   : count_reg;
        eff_balance = first_of_sequence ? '0   : balance_reg;
        eff_top     = first_of_sequence ? '0   : top_reg;
        eff_zero    = first_of_sequence ? 1'b0 : zero_seen_reg;

        full = (eff_count == FULL_COUNT);
        good = (sample > threshold_reg);
        pos  = eff_count + CW'(1);

        balance_next = good ? (eff_balance - BW'(1)) : (eff_balance + BW'(1));
        nonneg       = !balance_next[BW-1];
        bal_idx      = balance_next[CW-1:0];

        hit      = nonneg && (bal_idx < eff_top);
        new_top  = nonneg && (bal_idx != '0) && (bal_idx > eff_top);
        new_zero = nonneg && (bal_idx == '0) && !eff_zero;

        wr_en   = accept && !full && (new_top || new_zero);
        wr_addr = AW'(bal_idx);
        rd_addr = nonneg ? (AW'(bal_idx) + AW'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            balance_reg   <= '0;
            count_reg     <= '0;
            top_reg       <= '0;
            zero_seen_reg <= 1'b0;
        end
        else if (accept && !full)
        begin
            balance_reg   <= balance_next;
            count_reg     <= pos;
            top_reg       <= new_top ? bal_idx : eff_top;
            zero_seen_reg <= eff_zero || new_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= pos;
        end
        if (accept)
        begin
            rd_data_reg <= pos_mem[rd_addr];
        end
    end

    // Lookup stage: hold the sample's flags until the read data arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_restart_reg <= first_of_sequence;
            s1_full_reg    <= full;
            s1_neg_reg     <= !nonneg;
            s1_hit_reg     <= hit;
            s1_pos_reg     <= pos;
        end
    end

    // Best run: a negative balance makes the whole prefix qualify; otherwise
    // the run starts after the first position one balance step higher.
    always_comb
    begin
        best_cur = s1_restart_reg ? '0 : best_reg;
        run_len  = s1_pos_reg - rd_data_reg;
        priority if (s1_full_reg)
        begin
            best_next = best_cur;
        end
        else if (s1_neg_reg)
        begin
            best_next = s1_pos_reg;
        end
        else if (s1_hit_reg && (run_len > best_cur))
        begin
            best_next = run_len;
        end
        else
        begin
            best_next = best_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                best_reg <= best_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            best_length_reg <= BEST_W'(best_next);
            overflow_reg    <= s1_full_reg;
        end
    end

    // A dropped sample of a full sequence leaves the lookup stage.
    assign drop_done = advance && s1_valid_reg && s1_full_reg && !s1_restart_reg;

    // Checks
    `LMAW_ASSERT(a_count_bounded, count_reg <= FULL_COUNT, "sample count past MAX_LEN")
    `LMAW_ASSERT(a_top_within_count, top_reg <= count_reg, "recorded balance exceeds count")
    `LMAW_ASSERT_IMPLY(a_no_rw_collision, wr_en, wr_addr != rd_addr, "memory read/write collide")
    `LMAW_ASSERT_IMPLY(a_drop_keeps_best, drop_done, best_next == best_reg, "drop changed best")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
module tb;
    import lmaw_pkg::*;

    localparam int SEQ_MAX     = MAX_LEN_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 13;
    localparam int HOLD_CYCLES = 120;
    localparam int REPORT_MAX  = 10;

    // One expected result: the longest run so far and the overflow flag.
    typedef struct packed
    {
        logic [BEST_W-1:0] best;
        logic              ovf;
    } run_result_t;

    // Track the longest majority-above run of the current sequence and
    // compare each result transaction against the oldest prediction.
    class run_length_scoreboard;
        logic [THRESHOLD_W-1:0] thresh;
        int                     balance;
        int                     seq_count;
        int                     best_run;
        int                     first_pos [SEQ_MAX+2];
        bit                     seen [SEQ_MAX+2];
        run_result_t            expected_runs [$];
        int                     mismatches;

        function new();
            thresh     = THRESHOLD_RESET;
            mismatches = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            balance   = 0;
            seq_count = 0;
            best_run  = 0;
            foreach (seen[k])
                seen[k] = 1'b0;
        endfunction

        function void set_threshold(logic [THRESHOLD_W-1:0] value);
            thresh = value;
        endfunction

        // Advance the sequence by one accepted sample and queue its result.
        function void note_sample(logic [SAMPLE_W-1:0] value, logic restart);
            run_result_t r;
            int          span;
            r.ovf = 1'b0;
            if (restart)
                clear_sequence();
            if (seq_count >= SEQ_MAX)
                r.ovf = 1'b1;
            else
            begin
                seq_count++;
                if (value > thresh)
                    balance--;
                else
                    balance++;
                if (balance < 0)
                    best_run = seq_count;
                else
                begin
                    if (balance + 1 < SEQ_MAX + 2 && seen[balance+1])
                    begin
                        span = seq_count - first_pos[balance+1];
                        if (span > best_run)
                            best_run = span;
                    end
                    if (!seen[balance])
                    begin
                        seen[balance]      = 1'b1;
                        first_pos[balance] = seq_count;
                    end
                end
            end
            r.best = best_run[BEST_W-1:0];
            expected_runs.push_back(r);
        endfunction

        function void check_result(logic [BEST_W-1:0] best, logic ovf);
            run_result_t r;
            if (expected_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: best_length %0d overflow %0d", best, ovf);
                return;
            end
            r = expected_runs.pop_front();
            if (best !== r.best || ovf !== r.ovf)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: best_length exp %0d got %0d, overflow exp %0d got %0d",
                             r.best, best, r.ovf, ovf);
            end
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [THRESHOLD_W-1:0] cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    sample;
    logic                   first_of_sequence;
    logic                   out_valid;
    logic                   out_stall;
    logic [BEST_W-1:0]      best_length;
    logic                   overflow;

    run_length_scoreboard   sb = new();

    // Threshold as last written; steers sample generation toward good/bad.
    logic [THRESHOLD_W-1:0] cur_threshold;
    // Suppress random idling on both sides while set.
    bit                     quiet;
    // Ask the receiver for one long hold-off.
    bit                     hold_req;
    int                     cycle_count;

    longest_majority_above_window #(.MAX_LEN(SEQ_MAX)) dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample            (sample),
        .first_of_sequence (first_of_sequence),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .best_length       (best_length),
        .overflow          (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run. Count cycles here, independent of stimulus.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Receiver: stall at random, drop stalls entirely while quiet, and
    // hold off for a long stretch once asked so the block backs up into
    // its input channel.
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Check every completed result transaction. A result is registered
    // on acceptance, so the matching prediction is always queued first.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(best_length, overflow);
    end

    // Offer one input transaction, starting and ending on a falling edge.
    // Idle first at random; hold the payload until in_stall drops.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid          <= 1'b1;
        sample            <= value;
        first_of_sequence <= restart;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(value, restart);
        @(negedge clk);
    endtask

    // Drain every outstanding result, then write the threshold while idle.
    task automatic write_threshold(input logic [THRESHOLD_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_threshold(value);
        cur_threshold = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Draw a sample that is good with the given percent chance, relative
    // to the current threshold. At threshold 255 nothing can be good.
    function automatic logic [SAMPLE_W-1:0] pick_sample(int good_pct);
        if ($urandom_range(0, 99) < good_pct && cur_threshold != 8'hFF)
            return SAMPLE_W'($urandom_range(int'(cur_threshold) + 1, 255));
        return SAMPLE_W'($urandom_range(0, int'(cur_threshold)));
    endfunction

    // Mostly well-formed sequences with random content and varied good
    // ratios; a few continue the previous sequence, restart mid-way, or
    // carry fully random samples.
    task automatic run_sequences(input int n_items);
        int sent;
        int run_len;
        int good_pct;
        int k;
        logic restart;
        logic [SAMPLE_W-1:0] value;
        sent = 0;
        while (sent < n_items)
        begin
            run_len  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40)
                                                  : $urandom_range(41, 250);
            good_pct = 15 + 20 * $urandom_range(0, 3) + $urandom_range(0, 10);
            for (k = 0; k < run_len && sent < n_items; k++)
            begin
                restart = (k == 0) ? ($urandom_range(0, 9) != 0)
                                   : ($urandom_range(0, 99) == 0);
                value   = ($urandom_range(0, 9) == 0) ? SAMPLE_W'($urandom_range(0, 255))
                                                      : pick_sample(good_pct);
                send_sample(value, restart);
                sent++;
            end
        end
    endtask

    // Fill one sequence to its limit, run past it, then restart on the
    // full sequence. Ask for the long receiver hold-off partway through.
    task automatic run_full_sequence();
        int k;
        int good_pct;
        good_pct = 50;
        send_sample(pick_sample(good_pct), 1'b1);
        for (k = 1; k < SEQ_MAX + 8; k++)
        begin
            if (k % 64 == 0)
                good_pct = $urandom_range(35, 65);
            if (k == 400)
                hold_req = 1'b1;
            send_sample(pick_sample(good_pct), 1'b0);
        end
        send_sample(pick_sample(good_pct), 1'b1);
        for (k = 0; k < 10; k++)
            send_sample(pick_sample(good_pct), 1'b0);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        sample            = '0;
        first_of_sequence = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        cur_threshold     = THRESHOLD_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset threshold of 8. Hit good/bad at the boundary,
        // field extremes, a negative balance, a lookup hit after the
        // balance returns, and back-to-back restarts.
        send_sample(8'd9,   1'b0);
        send_sample(8'd8,   1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0,   1'b0);
        send_sample(8'd0,   1'b0);
        send_sample(8'd0,   1'b0);
        send_sample(8'd9,   1'b0);
        send_sample(8'd9,   1'b0);
        send_sample(8'd9,   1'b0);
        send_sample(8'd200, 1'b1);
        send_sample(8'd8,   1'b1);
        send_sample(8'd7,   1'b0);
        send_sample(8'd10,  1'b0);
        send_sample(8'd10,  1'b0);
        send_sample(8'd128, 1'b0);
        send_sample(8'd127, 1'b1);

        // Lowest threshold: only a zero sample is bad.
        write_threshold(8'd0);
        send_sample(8'd0, 1'b1);
        send_sample(8'd1, 1'b0);
        run_sequences(400);

        // Highest threshold: nothing is good, balance only climbs.
        write_threshold(8'hFF);
        send_sample(8'hFF, 1'b1);
        run_sequences(300);

        // Mid threshold: one sequence driven to its limit and beyond.
        write_threshold(THRESHOLD_W'($urandom_range(1, 254)));
        run_full_sequence();

        // Another mid threshold; run the first part with no idling at all.
        write_threshold(THRESHOLD_W'($urandom_range(1, 254)));
        quiet = 1'b1;
        run_sequences(200);
        quiet = 1'b0;
        run_sequences(150);

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
